// ===== src/mapc_pkg.sv =====
// Shared types, codes and sizes of the multi-agent plan checker.
// No dependencies; every other file imports this package.
package mapc_pkg;

    localparam int MAX_AGENTS = 256;
    localparam int AGENT_W    = $clog2(MAX_AGENTS);
    localparam int CNT_W      = AGENT_W + 1;
    localparam int COORD_BITS = 10;
    localparam int TIME_BITS  = 16;
    localparam int CFG_W      = 9;
    localparam int KEY_W      = 2 * AGENT_W + 1;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]     IDX_MAX  = CNT_W'(MAX_AGENTS + 1);

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_GOAL   = 2'd1,
        MODE_PLAN   = 2'd2,
        MODE_FINISH = 2'd3
    } mode_t;

    localparam logic [1:0] HEAD_PY = 2'd0;
    localparam logic [1:0] HEAD_NX = 2'd1;
    localparam logic [1:0] HEAD_NY = 2'd2;
    localparam logic [1:0] HEAD_PX = 2'd3;

    localparam logic [3:0] V_VALID    = 4'd0;
    localparam logic [3:0] V_EMPTY    = 4'd1;
    localparam logic [3:0] V_GOAL     = 4'd2;
    localparam logic [3:0] V_START    = 4'd3;
    localparam logic [3:0] V_SIZE     = 4'd4;
    localparam logic [3:0] V_REAPPEAR = 4'd5;
    localparam logic [3:0] V_BAD_ROT  = 4'd6;
    localparam logic [3:0] V_MOVE_ROT = 4'd7;
    localparam logic [3:0] V_BAD_MOVE = 4'd8;
    localparam logic [3:0] V_VERTEX   = 4'd9;
    localparam logic [3:0] V_EDGE     = 4'd10;

    typedef struct packed {
        logic                  p;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [1:0]            h;
    } slot_t;

    // classified beat passed from front to back
    typedef struct packed {
        mode_t            mode;
        slot_t            s;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] idx;
        logic             last;
    } item_t;

endpackage

// ===== src/multi_agent_plan_checker.sv =====
// In the back end a start/goal beat is stored directly from idle; a plan beat of agent k walks
// the earlier agents in the conflict walk, which reads one earlier agent per cycle; a short
// configuration adds a sweep over the missing entries; finish runs the goal walk to the verdict.
// The back-end walks bound the rate of beats; a four-beat queue lets the front keep accepting.
// Reset: synchronous, active-low aresetn clears control state; the stores hold no defined
// contents until written.
module multi_agent_plan_checker
    import mapc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic                  s_present,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [1:0]            s_heading,
    input  logic                  s_last_entry,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_verdict,
    output logic [TIME_BITS-1:0]  m_fail_time,
    output logic [AGENT_W-1:0]    m_fail_agent
);

    logic  q_full, q_push, q_valid, q_pop;
    item_t push_item, head_item;

    mapc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_present    (s_present),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_heading    (s_heading),
        .s_last_entry (s_last_entry),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    mapc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_item  (head_item)
    );

    mapc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict),
        .m_fail_time  (m_fail_time),
        .m_fail_agent (m_fail_agent)
    );

`ifndef ASSERT_OFF
    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= V_EDGE))
        else $error("verdict code out of range");

    a_no_loc_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict < V_SIZE) |-> (m_fail_time == '0 && m_fail_agent == '0))
        else $error("failure location on a run-level verdict");

    a_size_agent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict == V_SIZE) |-> (m_fail_agent == '0 && m_fail_time != '0))
        else $error("size mismatch with bad location");
`endif

endmodule

// ===== src/mapc_front.sv =====
// Front end: accepts input beats, tracks the entry index and classifies each beat.
// Depends on mapc_pkg.
module mapc_front
    import mapc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic                  s_present,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [1:0]            s_heading,
    input  logic                  s_last_entry,
    input  logic                  q_full,
    output logic                  q_push,
    output item_t                 q_item
);

    logic [CNT_W-1:0] entry_index_reg, entry_index_next;
    logic [CNT_W-1:0] idx_inc;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign idx_inc = (entry_index_reg < IDX_MAX) ? entry_index_reg + CNT_W'(1) : entry_index_reg;

    always_comb begin
        q_item.mode = mode_t'(s_mode);
        q_item.s    = '0;
        if (s_present) begin
            q_item.s = '{p: 1'b1, x: s_pos_x, y: s_pos_y, h: s_heading};
        end
        q_item.k    = entry_index_reg;
        q_item.idx  = idx_inc;
        q_item.last = s_last_entry;

        entry_index_next = entry_index_reg;
        if (q_push) begin
            if (mode_t'(s_mode) == MODE_FINISH || s_last_entry) begin
                entry_index_next = '0;
            end else begin
                entry_index_next = idx_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_index_reg <= '0;
        end else begin
            entry_index_reg <= entry_index_next;
        end
    end

endmodule

// ===== src/mapc_fifo.sv =====
// Short queue of classified beats between front and back.
// Depends on mapc_pkg.
module mapc_fifo
    import mapc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  out_valid,
    input  logic  pop,
    output item_t out_item
);

    item_t          mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            do_pop;

    assign full      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign do_pop    = pop && out_valid;
    assign out_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + (Q_AW+1)'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/mapc_back.sv =====
// Back end: stores, move and conflict checks, goal walk and verdict register.
// Depends on mapc_pkg.
module mapc_back
    import mapc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  q_valid,
    input  item_t                 q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_verdict,
    output logic [TIME_BITS-1:0]  m_fail_time,
    output logic [AGENT_W-1:0]    m_fail_agent
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ENTRY  = 7'b0000010,
        ST_PAIR   = 7'b0000100,
        ST_CLOSE  = 7'b0001000,
        ST_SWEEP  = 7'b0010000,
        ST_GOAL   = 7'b0100000,
        ST_REPORT = 7'b1000000
    } state_t;

    function automatic logic [3:0] move_code(input slot_t pv, input slot_t s);
        logic same_cell;
        logic fwd;
        logic [1:0] dh;
        same_cell = (pv.x == s.x) && (pv.y == s.y);
        dh        = s.h - pv.h;
        case (pv.h)
            HEAD_PY: fwd = (s.x == pv.x) && ({1'b0, s.y} == {1'b0, pv.y} + (COORD_BITS+1)'(1));
            HEAD_NX: fwd = (pv.x != '0) && (s.x == pv.x - COORD_BITS'(1)) && (s.y == pv.y);
            HEAD_NY: fwd = (pv.y != '0) && (s.y == pv.y - COORD_BITS'(1)) && (s.x == pv.x);
            default: fwd = ({1'b0, s.x} == {1'b0, pv.x} + (COORD_BITS+1)'(1)) && (s.y == pv.y);
        endcase
        if (same_cell) begin
            move_code = (dh == 2'd2) ? V_BAD_ROT : V_VALID;
        end else if (pv.h != s.h) begin
            move_code = V_MOVE_ROT;
        end else if (!fwd) begin
            move_code = V_BAD_MOVE;
        end else begin
            move_code = V_VALID;
        end
    endfunction

    // stores
    slot_t start_mem [MAX_AGENTS];
    slot_t goal_mem  [MAX_AGENTS];
    slot_t bank_a    [MAX_AGENTS];
    slot_t bank_b    [MAX_AGENTS];
    slot_t ls_mem    [MAX_AGENTS];
    slot_t start_rd, goal_rd, a_rd, b_rd, ls_rd;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      agent_count_reg, agent_count_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  rdv_reg, rdv_next;
    logic [AGENT_W-1:0]    dly_reg, dly_next;
    logic [TIME_BITS-1:0]  ts_reg, ts_next;
    logic [3:0]            fe_reg, fe_next;
    logic [TIME_BITS-1:0]  et_reg, et_next;
    logic [AGENT_W-1:0]    ea_reg, ea_next;
    logic [CNT_W-1:0]      start_len_reg, start_len_next;
    logic [CNT_W-1:0]      goal_len_reg, goal_len_next;
    logic                  start_bad_reg, start_bad_next;
    logic                  pend_v_reg, pend_v_next;
    logic [KEY_W-1:0]      pend_key_reg, pend_key_next;
    logic [3:0]            pend_code_reg, pend_code_next;
    logic [AGENT_W-1:0]    pend_agent_reg, pend_agent_next;
    logic [MAX_AGENTS-1:0] ended_reg, ended_next;
    logic                  sel_reg, sel_next;
    logic                  miss_reg, miss_next;
    logic                  m_valid_reg, m_valid_next;
    logic [3:0]            m_verdict_reg, m_verdict_next;
    logic [TIME_BITS-1:0]  m_time_reg, m_time_next;
    logic [AGENT_W-1:0]    m_agent_reg, m_agent_next;
    item_t                 it_reg, it_next;
    slot_t                 pk_reg, pk_next;

    logic [CNT_W-1:0]   n_eff;
    logic [AGENT_W-1:0] rd_addr;
    logic [AGENT_W-1:0] kk;
    logic               loop_st, issue, loop_done;
    logic [CNT_W-1:0]   limit;
    slot_t              c_rd, p_rd, lsel;
    logic               start_we, goal_we, c_we, ls_we;
    logic [AGENT_W-1:0] c_waddr;
    slot_t              c_wdata, ls_wdata;
    logic               prop_v;
    logic [KEY_W-1:0]   prop_key;
    logic [3:0]         prop_code;
    logic [AGENT_W-1:0] prop_agent;
    logic [3:0]         mc;

    assign n_eff = (int'(agent_count_reg) > MAX_AGENTS) ? CNT_W'(MAX_AGENTS)
                                                         : CNT_W'(agent_count_reg);
    assign c_rd  = sel_reg ? b_rd : a_rd;
    assign p_rd  = sel_reg ? a_rd : b_rd;
    assign kk    = it_reg.k[AGENT_W-1:0];
    assign mc    = move_code(p_rd, it_reg.s);

    assign loop_st   = (state_reg == ST_PAIR) || (state_reg == ST_SWEEP)
                    || (state_reg == ST_GOAL);
    assign limit     = (state_reg == ST_PAIR) ? it_reg.k : n_eff;
    assign issue     = loop_st && (cnt_reg < limit);
    assign loop_done = loop_st && !issue && !rdv_reg;
    assign rd_addr   = (state_reg == ST_IDLE) ? q_item.k[AGENT_W-1:0] : cnt_reg[AGENT_W-1:0];
    assign lsel      = ended_reg[dly_reg] ? ls_rd : p_rd;

    assign q_pop        = (state_reg == ST_IDLE) && q_valid;
    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_fail_time  = m_time_reg;
    assign m_fail_agent = m_agent_reg;

    always_comb begin
        state_next       = state_reg;
        agent_count_next = cfg_wr_en ? cfg_wr_data : agent_count_reg;
        cnt_next         = issue ? cnt_reg + CNT_W'(1) : cnt_reg;
        rdv_next         = issue;
        dly_next         = cnt_reg[AGENT_W-1:0];
        ts_next          = ts_reg;
        fe_next          = fe_reg;
        et_next          = et_reg;
        ea_next          = ea_reg;
        start_len_next   = start_len_reg;
        goal_len_next    = goal_len_reg;
        start_bad_next   = start_bad_reg;
        ended_next       = ended_reg;
        sel_next         = sel_reg;
        miss_next        = miss_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_verdict_next   = m_verdict_reg;
        m_time_next      = m_time_reg;
        m_agent_next     = m_agent_reg;
        it_next          = it_reg;
        pk_next          = pk_reg;
        start_we         = 1'b0;
        goal_we          = 1'b0;
        c_we             = 1'b0;
        c_waddr          = kk;
        c_wdata          = it_reg.s;
        ls_we            = 1'b0;
        ls_wdata         = (ts_reg == '0) ? slot_t'('0) : p_rd;
        prop_v           = 1'b0;
        prop_key         = '0;
        prop_code        = V_VALID;
        prop_agent       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    it_next = q_item;
                    case (q_item.mode)
                        MODE_START: begin
                            start_we = !q_item.k[AGENT_W];
                            if (q_item.last) begin
                                start_len_next = q_item.idx;
                            end
                        end
                        MODE_GOAL: begin
                            goal_we = !q_item.k[AGENT_W];
                            if (q_item.last) begin
                                goal_len_next = q_item.idx;
                            end
                        end
                        MODE_PLAN: begin
                            state_next = (q_item.k < n_eff) ? ST_ENTRY : ST_CLOSE;
                        end
                        default: begin
                            state_next = ST_GOAL;
                            cnt_next   = '0;
                            miss_next  = (goal_len_reg != n_eff);
                        end
                    endcase
                end
            end
            ST_ENTRY: begin
                pk_next = p_rd;
                c_we    = 1'b1;
                if (ts_reg == '0 && it_reg.s != start_rd) begin
                    start_bad_next = 1'b1;
                end
                if (!it_reg.s.p) begin
                    if (!ended_reg[kk]) begin
                        ended_next[kk] = 1'b1;
                        ls_we          = 1'b1;
                    end
                end else if (ts_reg != '0) begin
                    if (ended_reg[kk]) begin
                        prop_v    = 1'b1;
                        prop_code = V_REAPPEAR;
                    end else if (mc != V_VALID) begin
                        prop_v    = 1'b1;
                        prop_code = mc;
                    end
                    prop_key   = {kk, {(AGENT_W+1){1'b0}}};
                    prop_agent = kk;
                end
                cnt_next = '0;
                if (it_reg.s.p && ts_reg != '0 && kk != '0) begin
                    state_next = ST_PAIR;
                end else begin
                    state_next = ST_CLOSE;
                end
            end
            ST_PAIR: begin
                // walk earlier agents, one per cycle; read data arrives in the cycle after its address
                if (rdv_reg && c_rd.p && p_rd.p) begin
                    prop_agent = dly_reg;
                    if (c_rd.x == it_reg.s.x && c_rd.y == it_reg.s.y) begin
                        prop_v    = 1'b1;
                        prop_code = V_VERTEX;
                        prop_key  = {dly_reg, kk, 1'b0};
                    end else if (pk_reg.p && c_rd.x == pk_reg.x && c_rd.y == pk_reg.y
                                 && p_rd.x == it_reg.s.x && p_rd.y == it_reg.s.y) begin
                        prop_v    = 1'b1;
                        prop_code = V_EDGE;
                        prop_key  = {dly_reg, kk, 1'b1};
                    end
                end
                if (loop_done) begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (!it_reg.last) begin
                    state_next = ST_IDLE;
                end else begin
                    if (ts_reg == '0) begin
                        if (it_reg.idx != n_eff) begin
                            start_bad_next = 1'b1;
                        end
                    end else if (fe_reg == V_VALID) begin
                        if (it_reg.idx != n_eff) begin
                            fe_next = V_SIZE;
                            et_next = ts_reg;
                            ea_next = '0;
                        end else if (pend_v_reg) begin
                            fe_next = pend_code_reg;
                            et_next = ts_reg;
                            ea_next = pend_agent_reg;
                        end
                    end
                    if (it_reg.idx < n_eff) begin
                        // carry unwritten entries forward before the bank swap
                        state_next = ST_SWEEP;
                        cnt_next   = it_reg.idx;
                    end else begin
                        state_next = ST_IDLE;
                        sel_next   = !sel_reg;
                        ts_next    = (ts_reg != TIME_MAX) ? ts_reg + TIME_BITS'(1) : ts_reg;
                    end
                end
            end
            ST_SWEEP: begin
                if (rdv_reg) begin
                    c_we    = 1'b1;
                    c_waddr = dly_reg;
                    c_wdata = p_rd;
                end
                if (loop_done) begin
                    state_next = ST_IDLE;
                    sel_next   = !sel_reg;
                    ts_next    = (ts_reg != TIME_MAX) ? ts_reg + TIME_BITS'(1) : ts_reg;
                end
            end
            ST_GOAL: begin
                if (rdv_reg && (!lsel.p || lsel != goal_rd)) begin
                    miss_next = 1'b1;
                end
                if (loop_done) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_time_next  = '0;
                    m_agent_next = '0;
                    if (ts_reg == '0) begin
                        m_verdict_next = V_EMPTY;
                    end else if (miss_reg) begin
                        m_verdict_next = V_GOAL;
                    end else if (start_bad_reg || start_len_reg != n_eff) begin
                        m_verdict_next = V_START;
                    end else begin
                        m_verdict_next = fe_reg;
                        if (fe_reg != V_VALID) begin
                            m_time_next  = et_reg;
                            m_agent_next = ea_reg;
                        end
                    end
                    // clear run state
                    ts_next        = '0;
                    fe_next        = V_VALID;
                    et_next        = '0;
                    ea_next        = '0;
                    start_len_next = '0;
                    goal_len_next  = '0;
                    start_bad_next = 1'b0;
                    ended_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        pend_v_next     = pend_v_reg;
        pend_key_next   = pend_key_reg;
        pend_code_next  = pend_code_reg;
        pend_agent_next = pend_agent_reg;
        if (prop_v && (!pend_v_reg || prop_key < pend_key_reg)) begin
            pend_v_next     = 1'b1;
            pend_key_next   = prop_key;
            pend_code_next  = prop_code;
            pend_agent_next = prop_agent;
        end
        if ((state_reg == ST_CLOSE && it_reg.last) || state_reg == ST_REPORT) begin
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            agent_count_reg <= CFG_W'(1);
            cnt_reg         <= '0;
            rdv_reg         <= 1'b0;
            ts_reg          <= '0;
            fe_reg          <= V_VALID;
            et_reg          <= '0;
            ea_reg          <= '0;
            start_len_reg   <= '0;
            goal_len_reg    <= '0;
            start_bad_reg   <= 1'b0;
            pend_v_reg      <= 1'b0;
            ended_reg       <= '0;
            sel_reg         <= 1'b0;
            miss_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            agent_count_reg <= agent_count_next;
            cnt_reg         <= cnt_next;
            rdv_reg         <= rdv_next;
            ts_reg          <= ts_next;
            fe_reg          <= fe_next;
            et_reg          <= et_next;
            ea_reg          <= ea_next;
            start_len_reg   <= start_len_next;
            goal_len_reg    <= goal_len_next;
            start_bad_reg   <= start_bad_next;
            pend_v_reg      <= pend_v_next;
            ended_reg       <= ended_next;
            sel_reg         <= sel_next;
            miss_reg        <= miss_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dly_reg        <= dly_next;
        pend_key_reg   <= pend_key_next;
        pend_code_reg  <= pend_code_next;
        pend_agent_reg <= pend_agent_next;
        m_verdict_reg  <= m_verdict_next;
        m_time_reg     <= m_time_next;
        m_agent_reg    <= m_agent_next;
        it_reg         <= it_next;
        pk_reg         <= pk_next;
    end

    always_ff @(posedge aclk) begin
        if (start_we) begin
            start_mem[q_item.k[AGENT_W-1:0]] <= q_item.s;
        end
        start_rd <= start_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (goal_we) begin
            goal_mem[q_item.k[AGENT_W-1:0]] <= q_item.s;
        end
        goal_rd <= goal_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (c_we && !sel_reg) begin
            bank_a[c_waddr] <= c_wdata;
        end
        a_rd <= bank_a[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (c_we && sel_reg) begin
            bank_b[c_waddr] <= c_wdata;
        end
        b_rd <= bank_b[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[kk] <= ls_wdata;
        end
        ls_rd <= ls_mem[rd_addr];
    end

endmodule
